// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the record store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/drbs_pkg.sv -----
// ----------------------------------------------------------------------------
// drbs_pkg
// Shared types, codes and defaults of the dual-bank record store.
// ----------------------------------------------------------------------------
package drbs_pkg;

    localparam int DRBS_SLOTS        = 128;
    localparam int DRBS_RECORD_BYTES = 248;

    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_SAVE = 2'd1;
    localparam logic [1:0] MODE_SYNC = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] offset;
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } drbs_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic       copied;
    } drbs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEQ,
        ST_RD_WAIT,
        ST_COPY,
        ST_MERGE,
        ST_RESP
    } drbs_state_t;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_WORK
    } drbs_src_t;

endpackage

// ----- hdl/drbs_bank.sv -----
// ----------------------------------------------------------------------------
// drbs_bank
// One bank: record byte memory and per-slot sequence id memory, each with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module drbs_bank
    import drbs_pkg::*;
#(
    parameter int SLOTS        = DRBS_SLOTS,
    parameter int RECORD_BYTES = DRBS_RECORD_BYTES
)
(
    input  logic                                  clk,
    input  logic                                  byte_we,
    input  logic [$clog2(SLOTS*RECORD_BYTES)-1:0] byte_waddr,
    input  logic [7:0]                            byte_wdata,
    input  logic [$clog2(SLOTS*RECORD_BYTES)-1:0] byte_raddr,
    output logic [7:0]                            byte_rdata,
    input  logic                                  seq_we,
    input  logic [$clog2(SLOTS)-1:0]              seq_wslot,
    input  logic [31:0]                           seq_wdata,
    input  logic [$clog2(SLOTS)-1:0]              seq_rslot,
    output logic [31:0]                           seq_rdata
);

    localparam int DEPTH = SLOTS * RECORD_BYTES;

    logic [7:0]  byte_mem [DEPTH];
    logic [31:0] seq_mem  [SLOTS];
    logic [7:0]  byte_rdata_reg;
    logic [31:0] seq_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        byte_rdata_reg <= byte_mem[byte_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seq_we)
        begin
            seq_mem[seq_wslot] <= seq_wdata;
        end
        seq_rdata_reg <= seq_mem[seq_rslot];
    end

    assign byte_rdata = byte_rdata_reg;
    assign seq_rdata  = seq_rdata_reg;

endmodule

// ----- hdl/drbs_work.sv -----
// ----------------------------------------------------------------------------
// drbs_work
// Working record memory. Per-byte valid bits make unwritten bytes read zero.
// ----------------------------------------------------------------------------
module drbs_work
    import drbs_pkg::*;
#(
    parameter int RECORD_BYTES = DRBS_RECORD_BYTES
)
(
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   we,
    input  logic [((RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1)-1:0] waddr,
    input  logic [7:0]                                             wdata,
    input  logic [((RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1)-1:0] raddr,
    output logic [7:0]                                             rdata
);

    logic [7:0]              mem [RECORD_BYTES];
    logic [RECORD_BYTES-1:0] vld_reg;
    logic                    rd_vld_reg;
    logic [7:0]              rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rdata_reg : 8'd0;

endmodule

// ----- hdl/dual_bank_record_store_core.sv -----
// Read: states LOOKUP, SEQ, RD_WAIT and RESP lie between transfer and result.
// Save item without commit: LOOKUP, SEQ, MERGE and RESP, with a COPY before
// MERGE when the working copy is loaded from bank B. A commit or sync copy runs
// in COPY, one byte per cycle through the bank memory ports.
// One item at a time. Reset empties both banks and the working record at once.
// ----------------------------------------------------------------------------
// dual_bank_record_store_core
// Sequencer for the mirrored two-bank record store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_bank_record_store_core
    import drbs_pkg::*;
#(
    parameter int SLOTS        = DRBS_SLOTS,
    parameter int RECORD_BYTES = DRBS_RECORD_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  drbs_in_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output drbs_out_t result
);

    localparam int ADDR_W = $clog2(SLOTS * RECORD_BYTES);
    localparam int SL_W   = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WI_W   = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int IDX_W  = $clog2(RECORD_BYTES + 1);
    localparam logic [8:0]       OFF_LIMIT = 9'(RECORD_BYTES);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0] IDX_END   = IDX_W'(RECORD_BYTES);

    drbs_state_t       state_reg, state_next;
    drbs_in_t          item_reg, item_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic              save_open_reg, save_open_next;
    logic [31:0]       work_seq_reg, work_seq_next;
    logic [SL_W-1:0]   fa_reg, fa_next, fb_reg, fb_next;
    logic [ADDR_W-1:0] ca_base_reg, ca_base_next, cb_base_reg, cb_base_next;
    logic [ADDR_W-1:0] fa_base_reg, fa_base_next, fb_base_reg, fb_base_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              rd_v_reg, rd_v_next;
    logic [WI_W-1:0]   rd_idx_reg, rd_idx_next;
    drbs_src_t         src_reg, src_next;
    logic              dst_a_reg, dst_a_next, dst_b_reg, dst_b_next;
    logic              dst_w_reg, dst_w_next;
    logic              fill_reg, fill_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        rdata_reg, rdata_next;
    logic              copied_reg, copied_next;
    drbs_out_t         result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic [SL_W-1:0]   cur_a_c, cur_b_c, fa_c, fb_c;
    logic              has_a, has_b, a_newer, seq_equal, off_ok, out_free;
    logic [ADDR_W-1:0] rd_off;
    logic [7:0]        a_rdata, b_rdata, w_rdata, src_data;
    logic [31:0]       a_seq_rdata, b_seq_rdata, seq_wdata;
    logic              a_seq_we, b_seq_we, merge_we, copy_done;
    logic              w_we;
    logic [WI_W-1:0]   w_waddr, w_raddr;
    logic [7:0]        w_wdata;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] r;
        r = (cnt == CNT_FULL) ? CNT_W'(1) : cnt + CNT_W'(1);
        return r;
    endfunction

    // current slot: one before the free slot, last slot when the bank is full
    assign cur_a_c = (cnt_a_reg == CNT_FULL) ? SL_W'(SLOTS - 1) : SL_W'(cnt_a_reg - CNT_W'(1));
    assign cur_b_c = (cnt_b_reg == CNT_FULL) ? SL_W'(SLOTS - 1) : SL_W'(cnt_b_reg - CNT_W'(1));
    // append slot: a full bank is erased and restarts at slot 0
    assign fa_c = (cnt_a_reg == CNT_FULL) ? '0 : SL_W'(cnt_a_reg);
    assign fb_c = (cnt_b_reg == CNT_FULL) ? '0 : SL_W'(cnt_b_reg);

    assign has_a     = (cnt_a_reg != '0);
    assign has_b     = (cnt_b_reg != '0);
    assign seq_equal = (a_seq_rdata == b_seq_rdata);
    assign a_newer   = has_a && (!has_b || (a_seq_rdata > b_seq_rdata));
    assign off_ok    = ({1'b0, item_reg.offset} < OFF_LIMIT);
    assign out_free  = !result_valid_reg || !result_stall;
    assign copy_done = (idx_reg == IDX_END) && !rd_v_reg;

    assign rd_off  = (state_reg == ST_COPY) ? ADDR_W'(idx_reg) : ADDR_W'(item_reg.offset);
    assign w_raddr = (idx_reg < IDX_END) ? idx_reg[WI_W-1:0] : '0;
    assign w_we    = merge_we || (rd_v_reg && dst_w_reg);
    assign w_waddr = merge_we ? item_reg.offset[WI_W-1:0] : rd_idx_reg;
    assign w_wdata = merge_we ? item_reg.data : src_data;

    always_comb
    begin
        case (src_reg)
            SRC_A:   src_data = a_rdata;
            SRC_B:   src_data = b_rdata;
            default: src_data = w_rdata;
        endcase
    end

    drbs_bank #(
        .SLOTS        (SLOTS),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_bank_a (
        .clk        (clk),
        .byte_we    (rd_v_reg && dst_a_reg),
        .byte_waddr (fa_base_reg + ADDR_W'(rd_idx_reg)),
        .byte_wdata (src_data),
        .byte_raddr (ca_base_reg + rd_off),
        .byte_rdata (a_rdata),
        .seq_we     (a_seq_we),
        .seq_wslot  (fa_reg),
        .seq_wdata  (seq_wdata),
        .seq_rslot  (cur_a_c),
        .seq_rdata  (a_seq_rdata)
    );

    drbs_bank #(
        .SLOTS        (SLOTS),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_bank_b (
        .clk        (clk),
        .byte_we    (rd_v_reg && dst_b_reg),
        .byte_waddr (fb_base_reg + ADDR_W'(rd_idx_reg)),
        .byte_wdata (src_data),
        .byte_raddr (cb_base_reg + rd_off),
        .byte_rdata (b_rdata),
        .seq_we     (b_seq_we),
        .seq_wslot  (fb_reg),
        .seq_wdata  (seq_wdata),
        .seq_rslot  (cur_b_c),
        .seq_rdata  (b_seq_rdata)
    );

    drbs_work #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_work (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_SEQ;
            end
            ST_SEQ:
            begin
                case (item_reg.mode)
                    MODE_READ:
                    begin
                        state_next = (has_a && off_ok) ? ST_RD_WAIT : ST_RESP;
                    end
                    MODE_SAVE:
                    begin
                        state_next = (!save_open_reg && has_b) ? ST_COPY : ST_MERGE;
                    end
                    MODE_SYNC:
                    begin
                        if ((!has_a && !has_b) || (has_a && has_b && seq_equal))
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_COPY;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RESP;
            end
            ST_COPY:
            begin
                if (copy_done)
                begin
                    state_next = fill_reg ? ST_MERGE : ST_RESP;
                end
            end
            ST_MERGE:
            begin
                state_next = item_reg.last ? ST_COPY : ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        item_next         = item_reg;
        cnt_a_next        = cnt_a_reg;
        cnt_b_next        = cnt_b_reg;
        save_open_next    = save_open_reg;
        work_seq_next     = work_seq_reg;
        fa_next           = fa_reg;
        fb_next           = fb_reg;
        ca_base_next      = ca_base_reg;
        cb_base_next      = cb_base_reg;
        fa_base_next      = fa_base_reg;
        fb_base_next      = fb_base_reg;
        idx_next          = idx_reg;
        rd_v_next         = 1'b0;
        rd_idx_next       = rd_idx_reg;
        src_next          = src_reg;
        dst_a_next        = dst_a_reg;
        dst_b_next        = dst_b_reg;
        dst_w_next        = dst_w_reg;
        fill_next         = fill_reg;
        status_next       = status_reg;
        rdata_next        = rdata_reg;
        copied_next       = copied_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        a_seq_we          = 1'b0;
        b_seq_we          = 1'b0;
        seq_wdata         = work_seq_reg;
        merge_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next   = item;
                    status_next = STAT_OK;
                    rdata_next  = 8'd0;
                    copied_next = 1'b0;
                end
            end
            ST_LOOKUP:
            begin
                fa_next      = fa_c;
                fb_next      = fb_c;
                ca_base_next = ADDR_W'(cur_a_c * RECORD_BYTES);
                cb_base_next = ADDR_W'(cur_b_c * RECORD_BYTES);
                fa_base_next = ADDR_W'(fa_c * RECORD_BYTES);
                fb_base_next = ADDR_W'(fb_c * RECORD_BYTES);
            end
            ST_SEQ:
            begin
                idx_next = '0;
                case (item_reg.mode)
                    MODE_READ:
                    begin
                        if (!has_a)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (!off_ok)
                        begin
                            status_next = STAT_RANGE;
                        end
                    end
                    MODE_SAVE:
                    begin
                        if (!save_open_reg)
                        begin
                            save_open_next = 1'b1;
                            if (has_b)
                            begin
                                work_seq_next = b_seq_rdata + 32'd1;
                                src_next      = SRC_B;
                                dst_a_next    = 1'b0;
                                dst_b_next    = 1'b0;
                                dst_w_next    = 1'b1;
                                fill_next     = 1'b1;
                            end
                            else
                            begin
                                work_seq_next = 32'd1;
                            end
                        end
                    end
                    MODE_SYNC:
                    begin
                        save_open_next = 1'b0;
                        fill_next      = 1'b0;
                        dst_w_next     = 1'b1;
                        if (!has_a && !has_b)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (has_a && has_b && seq_equal)
                        begin
                            status_next = STAT_OK;
                        end
                        else if (a_newer)
                        begin
                            work_seq_next = a_seq_rdata;
                            seq_wdata     = a_seq_rdata;
                            b_seq_we      = 1'b1;
                            cnt_b_next    = bump(cnt_b_reg);
                            src_next      = SRC_A;
                            dst_a_next    = 1'b0;
                            dst_b_next    = 1'b1;
                            copied_next   = 1'b1;
                        end
                        else
                        begin
                            work_seq_next = b_seq_rdata;
                            seq_wdata     = b_seq_rdata;
                            a_seq_we      = 1'b1;
                            cnt_a_next    = bump(cnt_a_reg);
                            src_next      = SRC_B;
                            dst_a_next    = 1'b1;
                            dst_b_next    = 1'b0;
                            copied_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                rdata_next = a_rdata;
            end
            ST_COPY:
            begin
                // issue one read a cycle, write it back in the cycle after
                if (idx_reg < IDX_END)
                begin
                    idx_next    = idx_reg + IDX_W'(1);
                    rd_v_next   = 1'b1;
                    rd_idx_next = idx_reg[WI_W-1:0];
                end
            end
            ST_MERGE:
            begin
                if (item_reg.has_byte)
                begin
                    if (off_ok)
                    begin
                        merge_we = 1'b1;
                    end
                    else
                    begin
                        status_next = STAT_RANGE;
                    end
                end
                if (item_reg.last)
                begin
                    a_seq_we       = 1'b1;
                    b_seq_we       = 1'b1;
                    cnt_a_next     = bump(cnt_a_reg);
                    cnt_b_next     = bump(cnt_b_reg);
                    src_next       = SRC_WORK;
                    dst_a_next     = 1'b1;
                    dst_b_next     = 1'b1;
                    dst_w_next     = 1'b0;
                    fill_next      = 1'b0;
                    idx_next       = '0;
                    save_open_next = 1'b0;
                    copied_next    = 1'b1;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    result_next.status    = status_reg;
                    result_next.read_data = rdata_reg;
                    result_next.copied    = copied_reg;
                    result_valid_next     = 1'b1;
                end
            end
            default:
            begin
                rd_v_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_a_reg        <= '0;
            cnt_b_reg        <= '0;
            save_open_reg    <= 1'b0;
            work_seq_reg     <= '0;
            rd_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_a_reg        <= cnt_a_next;
            cnt_b_reg        <= cnt_b_next;
            save_open_reg    <= save_open_next;
            work_seq_reg     <= work_seq_next;
            rd_v_reg         <= rd_v_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        ca_base_reg <= ca_base_next;
        cb_base_reg <= cb_base_next;
        fa_base_reg <= fa_base_next;
        fb_base_reg <= fb_base_next;
        idx_reg     <= idx_next;
        rd_idx_reg  <= rd_idx_next;
        src_reg     <= src_next;
        dst_a_reg   <= dst_a_next;
        dst_b_reg   <= dst_b_next;
        dst_w_reg   <= dst_w_next;
        fill_reg    <= fill_next;
        status_reg  <= status_next;
        rdata_reg   <= rdata_next;
        copied_reg  <= copied_next;
        result_reg  <= result_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, (cnt_a_reg <= CNT_FULL) && (cnt_b_reg <= CNT_FULL), "slot count beyond bank size")
    `ASSERT_NEXT(a_commit_copy, clk, rst_n, (state_reg == ST_MERGE) && item_reg.last, (state_reg == ST_COPY) && !save_open_reg, "commit did not start the copy")
    `ASSERT_IMPLIES(a_copied_bank, clk, rst_n, (state_reg == ST_RESP) && copied_reg, has_a || has_b, "copy reported with both banks empty")
    `ASSERT_IMPLIES(a_copy_idx, clk, rst_n, state_reg == ST_COPY, idx_reg <= IDX_END, "copy index past record end")

endmodule
